// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants
// Calibration record, queue item, register map and an arithmetic-shift helper.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned UtW        = 16;
  localparam int unsigned UpW        = 19;
  localparam int unsigned TempW      = 16;
  localparam int unsigned PresW      = 18;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] B6Offset  = 32'd4000;
  localparam logic [31:0] B4Bias    = 32'd32768;
  localparam logic [31:0] B7Scale   = 32'd50000;
  localparam logic [31:0] FinA      = 32'd3038;
  localparam logic [31:0] FinB      = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] FinC      = 32'd3791;
  localparam logic [31:0] TempRound = 32'd8;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_e;

  // Coefficients widened to 32 bits (signed ones sign extended).
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } cal_t;

  // Temperature result handed from front to back.
  typedef struct packed {
    logic [31:0]    b5;
    logic [UpW-1:0] up;
    logic           err;
  } tq_item_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

// ===== rtl/bpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div: pipelined unsigned divider
// One quotient bit per stage, W stages, side data carried alongside.
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int unsigned W   = 32,
  parameter int unsigned SbW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [W-1:0]   num_i,
  input  logic [W-1:0]   den_i,
  input  logic [SbW-1:0] sb_i,
  output logic           valid_o,
  output logic [W-1:0]   quo_o,
  output logic [SbW-1:0] sb_o
);

  logic [W-1:0]   rem_q [W];
  logic [W-1:0]   num_q [W];
  logic [W-1:0]   den_q [W];
  logic [SbW-1:0] sb_q  [W];
  logic           vld_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]   rem_in, num_in, den_in;
    logic [SbW-1:0] sb_in;
    logic           v_in;
    logic [W:0]     trial, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign sb_in  = sb_q[k-1];
      assign v_in   = vld_q[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_in, num_in[W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        num_q[k] <= {num_in[W-2:0], ge};
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign quo_o   = num_q[W-1];
  assign sb_o    = sb_q[W-1];

endmodule

// ===== rtl/bpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front: temperature path
// Takes raw readings, computes B5 through a signed divide, pushes to queue.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpc_pkg::cal_t                cal_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bpc_pkg::UtW-1:0]      ut_i,
  input  logic [bpc_pkg::UpW-1:0]      up_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output bpc_pkg::tq_item_t            push_item_o
);
  import bpc_pkg::*;

  localparam int unsigned SbW = DataW + UpW + 2;

  logic           en;
  logic           v1_q, v2_q;
  logic [UtW-1:0] ut1_q;
  logic [UpW-1:0] up1_q, up2_q;
  logic [31:0]    prod_q, prod_d, diff;
  logic [31:0]    x1, den, num, num_mag, den_mag;
  logic           sgn, err;
  logic           dv;
  logic [31:0]    quo, x1_o, x2;
  logic [UpW-1:0] up_o;
  logic           err_o, sgn_o;

  assign en         = ~q_full_i;
  assign in_ready_o = en;

  assign diff   = {16'b0, ut1_q} - cal_i.ac6;
  assign prod_d = diff * cal_i.ac5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ut1_q  <= ut_i;
      up1_q  <= up_i;
      prod_q <= prod_d;
      up2_q  <= up1_q;
    end
  end

  // divisor and dividend as magnitudes, sign kept aside
  assign x1      = asr32(prod_q, 15);
  assign den     = x1 + cal_i.md;
  assign num     = cal_i.mc << 11;
  assign err     = (den == '0);
  assign sgn     = num[31] ^ den[31];
  assign num_mag = num[31] ? -num : num;
  assign den_mag = den[31] ? -den : den;

  bpc_div #(
    .W   (DataW),
    .SbW (SbW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .num_i   (num_mag),
    .den_i   (den_mag),
    .sb_i    ({x1, up2_q, err, sgn}),
    .valid_o (dv),
    .quo_o   (quo),
    .sb_o    ({x1_o, up_o, err_o, sgn_o})
  );

  assign x2              = sgn_o ? -quo : quo;
  assign push_o          = dv & en;
  assign push_item_o.b5  = x1_o + x2;
  assign push_item_o.up  = up_o;
  assign push_item_o.err = err_o;

endmodule

// ===== rtl/bpc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_fifo: short queue between front and back
// Register-based, full and empty decoded from a registered count.
// ----------------------------------------------------------------------------
module bpc_fifo #(
  parameter int unsigned Depth = bpc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bpc_pkg::tq_item_t wdata_i,
  input  logic              pop_i,
  output bpc_pkg::tq_item_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import bpc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tq_item_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i)  rd_q <= inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

// ===== rtl/bpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back: pressure path
// B3, B4, B7, unsigned divide, final correction and saturation.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bpc_pkg::cal_t            cal_i,
  input  bpc_pkg::tq_item_t        item_i,
  input  logic                     q_empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [bpc_pkg::TempW-1:0] temp_o,
  output logic [bpc_pkg::PresW-1:0] pres_o,
  output logic                     err_o
);
  import bpc_pkg::*;

  localparam int unsigned SbW = DataW + 2;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v6_q, v7_q, vo_q;
  logic [31:0] b6;
  // stage 1
  logic [31:0] b5_1_q, p66_1_q, pa2_1_q, pa3_1_q;
  logic [UpW-1:0] up_1_q;
  logic err_1_q;
  // stage 2
  logic [31:0] sq, b5_2_q, x2a_2_q, x1b_2_q, mb2_2_q, mb1_2_q;
  logic [UpW-1:0] up_2_q;
  logic err_2_q;
  // stage 3
  logic [31:0] x3, t3, b3, x3p, b5_3_q, b3_3_q, tmp_3_q;
  logic [UpW-1:0] up_3_q;
  logic err_3_q;
  // stage 4
  logic [31:0] b5_4_q, b4p_4_q, b7_4_q, b4, dnum;
  logic err_4_q, err4, big;
  // divider out
  logic dv, big_o, err_d;
  logic [31:0] quo, b5_d, p;
  // stages 6, 7
  logic [31:0] ps8, p_6_q, psq_6_q, m7_6_q, b5_6_q;
  logic [31:0] p_7_q, m3_7_q, m7_7_q, b5_7_q;
  logic err_6_q, err_7_q;
  // output
  logic [31:0] fx1, fx2, pf, tf;
  logic [TempW-1:0] temp_d, temp_q;
  logic [PresW-1:0] pres_d, pres_q;
  logic err_q;

  assign en    = ~vo_q | out_ready_i;
  assign pop_o = en & ~q_empty_i;
  assign b6    = item_i.b5 - B6Offset;

  // stage 2 and 3 arithmetic: B3 is a signed divide by four, rounded toward zero
  assign sq  = asr32(p66_1_q, 12);
  assign x3  = asr32(mb2_2_q, 11) + x2a_2_q;
  assign t3  = (((cal_i.ac1 << 2) + x3) << cal_i.oss) + 32'd2;
  assign b3  = t3[31] ? asr32(t3 + 32'd3, 2) : asr32(t3, 2);
  assign x3p = asr32(x1b_2_q + asr32(mb1_2_q, 16) + 32'd2, 2);

  // divider feed: keep the dividend below 2^32 when B7 has its top bit set
  assign b4   = b4p_4_q >> 15;
  assign err4 = err_4_q | (b4 == '0);
  assign big  = b7_4_q[31];
  assign dnum = big ? b7_4_q : (b7_4_q << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v6_q <= dv;
      v7_q <= v6_q;
      vo_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b5_1_q  <= item_i.b5;
      up_1_q  <= item_i.up;
      err_1_q <= item_i.err;
      p66_1_q <= b6 * b6;
      pa2_1_q <= cal_i.ac2 * b6;
      pa3_1_q <= cal_i.ac3 * b6;

      b5_2_q  <= b5_1_q;
      up_2_q  <= up_1_q;
      err_2_q <= err_1_q;
      x2a_2_q <= asr32(pa2_1_q, 11);
      x1b_2_q <= asr32(pa3_1_q, 13);
      mb2_2_q <= cal_i.b2 * sq;
      mb1_2_q <= cal_i.b1 * sq;

      b5_3_q  <= b5_2_q;
      up_3_q  <= up_2_q;
      err_3_q <= err_2_q;
      b3_3_q  <= b3;
      tmp_3_q <= x3p + B4Bias;

      b5_4_q  <= b5_3_q;
      err_4_q <= err_3_q;
      b4p_4_q <= cal_i.ac4 * tmp_3_q;
      b7_4_q  <= ({13'b0, up_3_q} - b3_3_q) * (B7Scale >> cal_i.oss);

      p_6_q   <= p;
      psq_6_q <= asr32(p, 8) * asr32(p, 8);
      m7_6_q  <= FinB * p;
      b5_6_q  <= b5_d;
      err_6_q <= err_d;

      p_7_q   <= p_6_q;
      m3_7_q  <= psq_6_q * FinA;
      m7_7_q  <= m7_6_q;
      b5_7_q  <= b5_6_q;
      err_7_q <= err_6_q;

      temp_q  <= temp_d;
      pres_q  <= pres_d;
      err_q   <= err_7_q;
    end
  end

  bpc_div #(
    .W   (DataW),
    .SbW (SbW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (dnum),
    .den_i   (b4),
    .sb_i    ({b5_4_q, err4, big}),
    .valid_o (dv),
    .quo_o   (quo),
    .sb_o    ({b5_d, err_d, big_o})
  );

  assign p   = big_o ? (quo << 1) : quo;

  // final correction and saturation
  assign fx1 = asr32(m3_7_q, 16);
  assign fx2 = asr32(m7_7_q, 16);
  assign pf  = p_7_q + asr32(fx1 + fx2 + FinC, 4);
  assign tf  = asr32(b5_7_q + TempRound, 4);
  assign ps8 = pf;

  always_comb begin
    if (err_7_q) begin
      temp_d = '0;
    end else if ($signed(tf) > 32'sd32767) begin
      temp_d = 16'h7FFF;
    end else if ($signed(tf) < -32'sd32768) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = tf[TempW-1:0];
    end
    if (err_7_q || ps8[31]) begin
      pres_d = '0;
    end else if (ps8 > 32'd262143) begin
      pres_d = '1;
    end else begin
      pres_d = ps8[PresW-1:0];
    end
  end

  assign out_valid_o = vo_q;
  assign temp_o      = temp_q;
  assign pres_o      = pres_q;
  assign err_o       = err_q;

endmodule

// ===== rtl/barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: integer sensor compensation
// Turns raw temperature/pressure readings into 0.1 degC and pascals.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one raw temperature and raw
//    pressure pair per transaction; output channel (out_valid_o/out_ready_i)
//    returns one result transaction per input, in order.
//  - Calibration and oversampling are written over the APB port (pready is
//    tied high); write them only while the block holds no transactions.
//  - Throughput: one transaction per clock unless a stall holds it. Path:
//    2 input stages, a 32-stage divider on magnitudes (one quotient bit
//    per stage) for the signed B5 divide, the queue, 4 stages of multiplies,
//    a 32-stage unsigned pressure divider, then 3 final correction stages.
//  - The front (temperature) and back (pressure) halves run on separate
//    stall enables with a small queue between them. When the receiver holds
//    out_ready_i low, the back half freezes, the queue fills, and only then
//    does in_ready_o drop.
//  - Reset clears all pipeline valid bits and the queue; calibration
//    registers reset to zero. A zero divisor gives error with zeroed fields.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation #(
  parameter int unsigned QueueDepth = bpc_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bpc_pkg::UtW-1:0]     raw_temperature_i,
  input  logic [bpc_pkg::UpW-1:0]     raw_pressure_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bpc_pkg::TempW-1:0]   temperature_tenths_o,
  output logic [bpc_pkg::PresW-1:0]   pressure_pa_o,
  output logic                        error_o
);
  import bpc_pkg::*;

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;
  reg_idx_e    idx;
  logic        wr_en;
  cal_t        cal;

  logic     push, pop, q_full, q_empty;
  tq_item_t push_item, pop_item;

  // APB register file
  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_AC1_AC2: ac12_q <= pwdata;
        REG_AC3_AC4: ac34_q <= pwdata;
        REG_AC5_AC6: ac56_q <= pwdata;
        REG_B1_B2:   b12_q  <= pwdata;
        REG_MC_MD:   mcmd_q <= pwdata;
        REG_OSS:     oss_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AC1_AC2: prdata = ac12_q;
      REG_AC3_AC4: prdata = ac34_q;
      REG_AC5_AC6: prdata = ac56_q;
      REG_B1_B2:   prdata = b12_q;
      REG_MC_MD:   prdata = mcmd_q;
      REG_OSS:     prdata = {30'b0, oss_q};
      default:     prdata = '0;
    endcase
  end

  // widen coefficients: signed ones sign extend, AC4..AC6 zero extend
  assign cal.ac1 = {{16{ac12_q[31]}}, ac12_q[31:16]};
  assign cal.ac2 = {{16{ac12_q[15]}}, ac12_q[15:0]};
  assign cal.ac3 = {{16{ac34_q[31]}}, ac34_q[31:16]};
  assign cal.ac4 = {16'b0, ac34_q[15:0]};
  assign cal.ac5 = {16'b0, ac56_q[31:16]};
  assign cal.ac6 = {16'b0, ac56_q[15:0]};
  assign cal.b1  = {{16{b12_q[31]}}, b12_q[31:16]};
  assign cal.b2  = {{16{b12_q[15]}}, b12_q[15:0]};
  assign cal.mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
  assign cal.md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};
  assign cal.oss = oss_q;

  bpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ut_i        (raw_temperature_i),
    .up_i        (raw_pressure_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  bpc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (pop_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .item_i      (pop_item),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .temp_o      (temperature_tenths_o),
    .pres_o      (pressure_pa_o),
    .err_o       (error_o)
  );

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> temperature_tenths_o == '0 && pressure_pa_o == '0)
    else $error("error result with nonzero fields");
  a_ready_follows_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == !q_full) else $error("input ready out of step with queue");
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(ac12_q) && $stable(mcmd_q) && $stable(oss_q))
    else $error("calibration changed without a write");

endmodule

// ===== sim/tb_barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation: self-checking testbench
// Programs calibration sets over APB, streams raw temperature/pressure pairs
// with random gaps and stalls, and checks every compensated result in order
// against an independent integer predictor held in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation;
  import bpc_pkg::*;

  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [PresW-1:0] pres;
    logic             err;
  } reading_t;

  // Scoreboard: shadow calibration, integer compensation, in-order compare.
  class pressure_scoreboard;
    logic [31:0] cal [6];
    reading_t    readings_due [$];
    int          n_bad;

    function new();
      foreach (cal[i]) cal[i] = '0;
      n_bad = 0;
    endfunction

    function logic [31:0] sra(logic [31:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    function logic [31:0] ext16(logic [15:0] x);
      return {{16{x[15]}}, x};
    endfunction

    // Truncating signed divide; the one overflow case returns the dividend.
    function logic [31:0] sdivide(logic [31:0] a, logic [31:0] b);
      if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
      return $signed(a) / $signed(b);
    endfunction

    function reading_t compensate(logic [UtW-1:0] ut, logic [UpW-1:0] up);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p, t;
      int          oss, ts, ps;
      reading_t    r;
      ac1 = ext16(cal[REG_AC1_AC2][31:16]);  ac2 = ext16(cal[REG_AC1_AC2][15:0]);
      ac3 = ext16(cal[REG_AC3_AC4][31:16]);  ac4 = {16'b0, cal[REG_AC3_AC4][15:0]};
      ac5 = {16'b0, cal[REG_AC5_AC6][31:16]}; ac6 = {16'b0, cal[REG_AC5_AC6][15:0]};
      b1  = ext16(cal[REG_B1_B2][31:16]);    b2  = ext16(cal[REG_B1_B2][15:0]);
      mc  = ext16(cal[REG_MC_MD][31:16]);    md  = ext16(cal[REG_MC_MD][15:0]);
      oss = cal[REG_OSS][1:0];
      r = '{temp: '0, pres: '0, err: 1'b1};

      // temperature
      x1  = sra(({16'b0, ut} - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) return r;
      x2 = sdivide(mc << 11, den);
      b5 = x1 + x2;

      // pressure
      b6 = b5 - B6Offset;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sdivide(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + B4Bias)) >> 15;
      b7 = ({13'b0, up} - b3) * (B7Scale >> oss);
      if (b4 == 0) return r;
      if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;

      // final correction uses (p>>8) squared
      x1 = sra(p, 8);
      x1 = sra((x1 * x1) * FinA, 16);
      x2 = sra(FinB * p, 16);
      p  = p + sra(x1 + x2 + FinC, 4);

      t  = sra(b5 + TempRound, 4);
      ts = $signed(t);
      if (ts > 32767) ts = 32767;
      if (ts < -32768) ts = -32768;
      ps = $signed(p);
      if (ps < 0) ps = 0;
      if (ps > 262143) ps = 262143;
      r.temp = ts[15:0];
      r.pres = ps[17:0];
      r.err  = 1'b0;
      return r;
    endfunction

    function void note_input(logic [UtW-1:0] ut, logic [UpW-1:0] up);
      readings_due.push_back(compensate(ut, up));
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      if (readings_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", got);
        return;
      end
      want = readings_due.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: exp temp %0d pres %0d err %0b, got temp %0d pres %0d err %0b",
                   $signed(want.temp), want.pres, want.err,
                   $signed(got.temp), got.pres, got.err);
      end
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [UtW-1:0]   raw_temperature_i = '0;
  logic [UpW-1:0]   raw_pressure_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [TempW-1:0] temperature_tenths_o;
  logic [PresW-1:0] pressure_pa_o;
  logic             error_o;

  pressure_scoreboard sb = new();

  bit calm;       // no idling on either side while set
  bit hold_req;   // asks the receiver for one long hold-off

  always #1 clk_i = ~clk_i;

  barometric_pressure_compensation dut (.*);

  // Receiver: random back-pressure, plus one long hold counted here.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = calm || ($urandom_range(99) >= 26);
      end
    end
  end

  // Result monitor: sampled in the active region of the rising edge.
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{temp: temperature_tenths_o, pres: pressure_pa_o, err: error_o});

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = AddrW'(idx) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.cal[idx] = (idx == REG_OSS) ? (val & 32'd3) : val;
  endtask

  task automatic program_cal(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d, logic [31:0] e, logic [1:0] oss);
    reg_write(REG_AC1_AC2, a);
    reg_write(REG_AC3_AC4, b);
    reg_write(REG_AC5_AC6, c);
    reg_write(REG_B1_B2, d);
    reg_write(REG_MC_MD, e);
    reg_write(REG_OSS, {30'b0, oss});
  endtask

  // One input transaction; valid stays high until accepted.
  task automatic send_reading(logic [UtW-1:0] ut, logic [UpW-1:0] up);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    raw_temperature_i = ut;
    raw_pressure_i = up;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(ut, up);
  endtask

  // Wait, clock by clock, until every expected result has come back.
  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Drain: wait for every result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_results();
    repeat (120) @(posedge clk_i);
  endtask

  // Typical factory calibration, used as the base for perturbed sets.
  localparam logic [31:0] CalA = {16'd408, 16'hFFB8};        // AC1 408, AC2 -72
  localparam logic [31:0] CalB = {16'hC7D1, 16'd32741};      // AC3 -14383, AC4
  localparam logic [31:0] CalC = {16'd32757, 16'd23153};     // AC5, AC6
  localparam logic [31:0] CalD = {16'd6190, 16'd4};          // B1, B2
  localparam logic [31:0] CalE = {16'hDDF9, 16'd2868};       // MC -8711, MD

  function automatic logic [15:0] jitter(logic [15:0] v);
    return v + 16'($signed($urandom_range(400)) - 200);
  endfunction

  task automatic random_readings(int n);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        send_reading(16'($urandom), 19'($urandom));
      else
        send_reading(16'($urandom_range(36000, 20000)), 19'($urandom_range(120000, 10000)));
    end
  endtask

  initial begin
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset calibration: zero temperature divisor, every result flags error.
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(16'd27898, 19'd23843);
    drain();

    // Typical calibration, directed extremes across all oversampling modes.
    for (int o = 0; o < 4; o++) begin
      program_cal(CalA, CalB, CalC, CalD, CalE, 2'(o));
      send_reading(16'd27898, 19'd23843 << o);
      send_reading('0, '0);
      send_reading('1, '1);
      send_reading('0, '1);
      send_reading('1, '0);
      drain();
    end

    // Zero pressure divisor: AC4 of zero forces B4 to zero.
    program_cal(CalA, {CalB[31:16], 16'd0}, CalC, CalD, CalE, 2'd1);
    send_reading(16'd27898, 19'd23843);
    send_reading('1, '1);
    drain();

    // All ones everywhere, then every field at its lowest value.
    program_cal('1, '1, '1, '1, '1, 2'd3);
    send_reading('1, '1);
    send_reading('0, '0);
    send_reading(16'd30000, 19'd300000);
    drain();
    program_cal(32'h8000_8000, 32'h8000_0000, 32'h0000_0000, 32'h8000_8000,
                32'h8000_8000, 2'd0);
    send_reading('1, '1);
    send_reading('0, '0);
    drain();

    // Random part: perturbed realistic sets plus one fully random set.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 5)
        program_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
      else
        program_cal({jitter(CalA[31:16]), jitter(CalA[15:0])},
                    {jitter(CalB[31:16]), jitter(CalB[15:0])},
                    {jitter(CalC[31:16]), jitter(CalC[15:0])},
                    {jitter(CalD[31:16]), jitter(CalD[15:0])},
                    {jitter(CalE[31:16]), jitter(CalE[15:0])}, 2'($urandom));
      calm = (ph == 2);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        random_readings(110);
        // sender pauses until every result is back
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait_results();
        random_readings(110);
      end else begin
        random_readings(215);
      end
      calm = 1'b0;
      drain();
    end

    if (sb.n_bad == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
